### sv/hse_pkg.sv
// Shared constants for the heap sort engine.
`default_nettype none
package hse_pkg;
	localparam int VALUE_W = 32;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;
endpackage
`default_nettype wire

### sv/hse_ifs.sv
// Valid/ready channel interfaces for items, results and the configuration register.
`default_nettype none
interface hse_in_if;
	logic valid;
	logic ready;
	logic [hse_pkg::VALUE_W-1:0] item_value;
	logic item_last;
	modport source (output valid, output item_value, output item_last, input ready);
	modport sink (input valid, input item_value, input item_last, output ready);
endinterface

interface hse_out_if;
	logic valid;
	logic ready;
	logic [hse_pkg::VALUE_W-1:0] sorted_value;
	logic sorted_last;
	logic items_dropped;
	modport source (output valid, output sorted_value, output sorted_last,
		output items_dropped, input ready);
	modport sink (input valid, input sorted_value, input sorted_last,
		input items_dropped, output ready);
endinterface

interface hse_cfg_if;
	logic valid;
	logic ready;
	logic sort_descending;
	modport source (output valid, output sort_descending, input ready);
	modport sink (input valid, input sort_descending, output ready);
endinterface
`default_nettype wire

### sv/heap_sort_engine.sv
// Heap sort engine: collects a set of values in a dual-read memory and emits them sorted.
// Values are loaded one word per cycle until the word flagged last, which starts the sort;
// no new word is taken until the last sorted word has been handed to the output register.
// The sort builds a heap in place and then extracts the root repeatedly. At each sift level
// both children are read in the same cycle on the memory's two read ports and the compare
// and write-back happen when the data returns; when the path ends at a leaf, a final step
// places the sifted word there. Each heapify sift starts with the states S_HRD and S_HSET,
// each extraction passes through S_ERD and S_EXT, and the result side can stall an
// extraction. Words beyond MAX_ITEMS are discarded and flagged on every result of that set.
`default_nettype none
module heap_sort_engine #(
	parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = hse_pkg::DATA_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	hse_in_if.sink items,
	hse_out_if.source results,
	hse_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = AW + 2;

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_HRD = 3'd1;
	localparam logic [2:0] S_HSET = 3'd2;
	localparam logic [2:0] S_SIFT = 3'd3;
	localparam logic [2:0] S_PUT = 3'd4;
	localparam logic [2:0] S_ERD = 3'd5;
	localparam logic [2:0] S_EXT = 3'd6;

	function automatic logic [IW-1:0] child_l(input logic [AW-1:0] p);
		return {1'b0, p, 1'b1};
	endfunction

	function automatic logic [IW-1:0] child_r(input logic [AW-1:0] p);
		return {1'b0, p, 1'b0} + IW'(2);
	endfunction

	logic [DATA_WIDTH-1:0] mem [MAX_ITEMS];
	logic [DATA_WIDTH-1:0] rd0_q, rd1_q;

	logic [2:0] state_q, state_d;
	logic extract_q, extract_d;
	logic [AW-1:0] pos_q, pos_d, k_q, k_d;
	logic [DATA_WIDTH-1:0] x_q, x_d;
	logic [CW-1:0] count_q, count_d, count_m1, count_p;
	logic ovf_q, ovf_d, desc_q;
	logic ovalid_q, oload;
	logic [hse_pkg::VALUE_W-1:0] oval_q;
	logic olast_q, odrop_q;

	logic we;
	logic [AW-1:0] waddr, raddr0, raddr1;
	logic [DATA_WIDTH-1:0] wdata;
	logic out_free, sift_done, r_ok, pick_r, stop;
	logic [IW-1:0] len_ext, pick_idx, pick_l, pick_rc, head_l, head_r;
	logic [DATA_WIDTH-1:0] best;

	function automatic logic ranks_above(input logic d, input logic [DATA_WIDTH-1:0] a,
		input logic [DATA_WIDTH-1:0] b);
		return d ? (a > b) : (a < b);
	endfunction

	assign items.ready = (state_q == S_LOAD);
	assign cfg.ready = 1'b1;
	assign results.valid = ovalid_q;
	assign results.sorted_value = oval_q;
	assign results.sorted_last = olast_q;
	assign results.items_dropped = odrop_q;

	assign out_free = !ovalid_q || results.ready;
	assign count_m1 = count_q - CW'(1);
	assign count_p = count_q + CW'(1);
	assign len_ext = IW'(count_q);

	assign r_ok = child_r(pos_q) < len_ext;
	assign pick_r = r_ok && ranks_above(desc_q, rd1_q, rd0_q);
	assign best = pick_r ? rd1_q : rd0_q;
	assign pick_idx = pick_r ? child_r(pos_q) : child_l(pos_q);
	assign pick_l = child_l(pick_idx[AW-1:0]);
	assign pick_rc = child_r(pick_idx[AW-1:0]);
	assign head_l = child_l(k_q);
	assign head_r = child_r(k_q);
	assign stop = ranks_above(desc_q, x_q, best);

	always_comb begin
		logic [CW-1:0] nc;
		logic [CW-1:0] k0;
		state_d = state_q;
		extract_d = extract_q;
		pos_d = pos_q;
		k_d = k_q;
		x_d = x_q;
		count_d = count_q;
		ovf_d = ovf_q;
		we = 1'b0;
		waddr = pos_q;
		wdata = x_q;
		raddr0 = '0;
		raddr1 = count_m1[AW-1:0];
		sift_done = 1'b0;
		oload = 1'b0;
		nc = count_q;
		k0 = '0;
		case (state_q)
			S_LOAD: begin
				if (items.valid) begin
					if (count_q < CW'(MAX_ITEMS)) begin
						we = 1'b1;
						waddr = count_q[AW-1:0];
						wdata = DATA_WIDTH'(items.item_value);
						nc = count_p;
					end else begin
						ovf_d = 1'b1;
					end
					count_d = nc;
					if (items.item_last) begin
						k0 = nc >> 1;
						if (k0 == '0) begin
							extract_d = 1'b1;
							state_d = S_ERD;
						end else begin
							k0 = k0 - CW'(1);
							k_d = k0[AW-1:0];
							extract_d = 1'b0;
							state_d = S_HRD;
						end
					end
				end
			end
			S_HRD: begin
				raddr0 = k_q;
				state_d = S_HSET;
			end
			S_HSET: begin
				x_d = rd0_q;
				pos_d = k_q;
				raddr0 = head_l[AW-1:0];
				raddr1 = head_r[AW-1:0];
				state_d = S_SIFT;
			end
			S_SIFT: begin
				we = 1'b1;
				waddr = pos_q;
				if (stop) begin
					wdata = x_q;
					sift_done = 1'b1;
				end else begin
					wdata = best;
					pos_d = pick_idx[AW-1:0];
					if (pick_l < len_ext) begin
						raddr0 = pick_l[AW-1:0];
						raddr1 = pick_rc[AW-1:0];
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_PUT: begin
				we = 1'b1;
				sift_done = 1'b1;
			end
			S_ERD: begin
				state_d = S_EXT;
			end
			S_EXT: begin
				if (out_free) begin
					oload = 1'b1;
					if (count_q == CW'(1)) begin
						count_d = '0;
						ovf_d = 1'b0;
						state_d = S_LOAD;
					end else begin
						count_d = count_m1;
						x_d = rd1_q;
						pos_d = '0;
						if (count_q > CW'(2)) begin
							raddr0 = AW'(1);
							raddr1 = AW'(2);
							state_d = S_SIFT;
						end else begin
							we = 1'b1;
							waddr = '0;
							wdata = rd1_q;
							state_d = S_ERD;
						end
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
		if (sift_done) begin
			if (!extract_q && k_q != '0) begin
				k_d = k_q - AW'(1);
				state_d = S_HRD;
			end else begin
				extract_d = 1'b1;
				state_d = S_ERD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			extract_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
			desc_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			extract_q <= extract_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
			if (cfg.valid) begin
				desc_q <= cfg.sort_descending;
			end
			if (oload) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		k_q <= k_d;
		x_q <= x_d;
		if (oload) begin
			oval_q <= hse_pkg::VALUE_W'(rd0_q);
			olast_q <= (count_q == CW'(1));
			odrop_q <= ovf_q;
		end
	end
endmodule
`default_nettype wire

### sv/hse_checker.sv
// Port-level checks for the heap sort engine and the bind that attaches them.
`default_nettype none
module hse_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic items_valid,
	input wire logic items_ready,
	input wire logic items_last,
	input wire logic results_valid,
	input wire logic results_ready,
	input wire logic [hse_pkg::VALUE_W-1:0] results_value,
	input wire logic results_last,
	input wire logic results_dropped
);
	// A held result keeps its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && !results_ready |=> results_valid && $stable(results_value)
			&& $stable(results_last) && $stable(results_dropped))
		else $error("result word changed while stalled");

	// The word that closes a set starts a sort, so no word is taken right after it.
	a_sort_busy: assert property (@(posedge clk) disable iff (!arst_n)
		items_valid && items_ready && items_last |=> !items_ready)
		else $error("input taken right after the last word of a set");

	// Until the final result of a set sits in the output register, the input stays closed.
	a_no_load_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && results_ready && !results_last |=>
			!items_ready || (results_valid && results_last))
		else $error("input reopened before the set was fully emitted");

	// The overflow flag is the same on every result of one set.
	a_drop_steady: assert property (@(posedge clk) disable iff (!arst_n)
		results_valid && results_ready && !results_last |=>
			!results_valid || results_dropped == $past(results_dropped))
		else $error("overflow flag changed within a set");
endmodule

bind heap_sort_engine hse_checker u_hse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.items_valid(items.valid),
	.items_ready(items.ready),
	.items_last(items.item_last),
	.results_valid(results.valid),
	.results_ready(results.ready),
	.results_value(results.sorted_value),
	.results_last(results.sorted_last),
	.results_dropped(results.items_dropped)
);
`default_nettype wire
